FILE: src/ps2fr_pkg.sv
// ----------------------------------------------------------------------------
// ps2fr_pkg
// Types, constants and codes shared by the PS/2 frame receiver modules.
// ----------------------------------------------------------------------------
package ps2fr_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int FRAME_EDGES     = 11;
  localparam int LAST_DATA_BIT   = 7;
  localparam logic [15:0] GAP_RESET_VALUE = 16'd250;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_GAP_LIMIT_ADDR = 2'd0;

  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic        kind;
    logic        data_bit;
    logic [31:0] time_us;
  } in_item_t;

  typedef struct packed {
    logic       byte_stored;
    logic       byte_dropped;
    logic       read_valid;
    logic [7:0] read_byte;
  } out_item_t;

  typedef struct packed {
    logic       done;
    logic [7:0] data;
  } frame_evt_t;

  typedef struct packed {
    logic stored;
    logic dropped;
    logic hit;
  } queue_status_t;

endpackage

FILE: src/ps2_frame_receiver_fifo.sv
// ----------------------------------------------------------------------------
// ps2_frame_receiver_fifo
// PS/2 frame receiver with byte queue, one result per request.
//
//   channel  | ports                          | moves
//   ---------+--------------------------------+------------------------------
//   in       | in_valid/in_ready/in_data      | edge event or read request
//   out      | out_valid/out_ready/out_data   | store/drop/read result
//   cfg      | psel/penable/pwrite/paddr/...  | gap_limit_us at address 0
//
// one request per cycle while in_ready is high; the result passes the queue
// memory read stage, then the output register
// reset is synchronous, no clearing pass; queue slots are written before read
// in_ready stays high while the memory stage is empty or can move on
// ----------------------------------------------------------------------------
module ps2_frame_receiver_fifo
  import ps2fr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [15:0]   gap_r, gap_nxt;
  logic          p1_valid_r, p1_valid_nxt;
  queue_status_t p1_stat_r, p1_stat_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic          acc;
  logic          p1_adv;
  frame_evt_t    evt;
  queue_status_t q_stat;
  logic [7:0]    q_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_GAP_LIMIT_ADDR) ? {16'd0, gap_r} : '0;

  always_comb begin
    gap_nxt = gap_r;
    if (psel && penable && pwrite && paddr == REG_GAP_LIMIT_ADDR) begin
      gap_nxt = pwdata[15:0];
    end
  end

  assign p1_adv   = !out_valid_r || out_ready;
  assign in_ready = !p1_valid_r || p1_adv;
  assign acc      = in_valid && in_ready;

  ps2fr_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .edge_en   (acc && in_data.kind == KIND_EDGE),
    .data_bit  (in_data.data_bit),
    .time_us   (in_data.time_us),
    .gap_limit (gap_r),
    .evt       (evt)
  );

  ps2fr_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_req  (evt.done),
    .wr_byte (evt.data),
    .rd_req  (acc && in_data.kind == KIND_READ),
    .status  (q_stat),
    .rdata   (q_rdata)
  );

  always_comb begin
    p1_valid_nxt = p1_valid_r;
    p1_stat_nxt  = p1_stat_r;
    if (acc) begin
      p1_valid_nxt = 1'b1;
      p1_stat_nxt  = q_stat;
    end else if (p1_adv) begin
      p1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (p1_adv) begin
      out_valid_nxt             = p1_valid_r;
      out_data_nxt.byte_stored  = p1_stat_r.stored;
      out_data_nxt.byte_dropped = p1_stat_r.dropped;
      out_data_nxt.read_valid   = p1_stat_r.hit;
      out_data_nxt.read_byte    = p1_stat_r.hit ? q_rdata : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r       <= GAP_RESET_VALUE;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      gap_r       <= gap_nxt;
      p1_valid_r  <= p1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_stat_r  <= p1_stat_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_p1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r && !p1_adv |=> p1_valid_r && $stable(p1_stat_r))
    else $error("memory stage lost a request");

  a_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.read_valid |->
      !out_data_r.byte_stored && !out_data_r.byte_dropped)
    else $error("read result carries frame flags");

  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.read_valid |-> out_data_r.read_byte == 8'd0)
    else $error("byte on result without read hit");

endmodule

FILE: src/ps2fr_frame.sv
// ----------------------------------------------------------------------------
// ps2fr_frame
// Frame assembler: gap check, bit position counter and data byte shifter.
// ----------------------------------------------------------------------------
module ps2fr_frame
  import ps2fr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        edge_en,
  input  logic        data_bit,
  input  logic [31:0] time_us,
  input  logic [15:0] gap_limit,
  output frame_evt_t  evt
);

  logic [3:0]  bit_pos_r, bit_pos_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [31:0] last_time_r, last_time_nxt;

  logic [31:0] gap;
  logic        stale;
  logic [3:0]  pos_eff;
  logic [3:0]  pos_inc;
  logic [3:0]  bit_idx;
  logic [7:0]  shift_eff;
  logic [7:0]  shift_ins;
  logic        frame_done;

  always_comb begin
    gap       = time_us - last_time_r;
    stale     = gap > {16'd0, gap_limit};
    pos_eff   = stale ? 4'd0 : bit_pos_r;
    shift_eff = stale ? 8'd0 : shift_r;
    bit_idx   = pos_eff - 4'd1;
    shift_ins = shift_eff;
    if (pos_eff >= 4'd1 && pos_eff <= 4'(LAST_DATA_BIT + 1)) begin
      shift_ins[bit_idx[2:0]] = shift_eff[bit_idx[2:0]] | data_bit;
    end
    pos_inc    = pos_eff + 4'd1;
    frame_done = pos_inc >= 4'(FRAME_EDGES);

    bit_pos_nxt   = bit_pos_r;
    shift_nxt     = shift_r;
    last_time_nxt = last_time_r;
    if (edge_en) begin
      last_time_nxt = time_us;
      bit_pos_nxt   = frame_done ? 4'd0 : pos_inc;
      shift_nxt     = frame_done ? 8'd0 : shift_ins;
    end

    evt.done = edge_en && frame_done;
    evt.data = shift_ins;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_pos_r   <= 4'd0;
      shift_r     <= 8'd0;
      last_time_r <= 32'd0;
    end else begin
      bit_pos_r   <= bit_pos_nxt;
      shift_r     <= shift_nxt;
      last_time_r <= last_time_nxt;
    end
  end

endmodule

FILE: src/ps2fr_queue.sv
// ----------------------------------------------------------------------------
// ps2fr_queue
// Ring byte queue in a synchronous memory, one slot kept empty.
// ----------------------------------------------------------------------------
module ps2fr_queue
  import ps2fr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_req,
  input  logic [7:0]    wr_byte,
  input  logic          rd_req,
  output queue_status_t status,
  output logic [7:0]    rdata
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  logic [7:0]       mem [QUEUE_DEPTH];
  logic [7:0]       rdata_r;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] wr_next;
  logic [IDX_W-1:0] rd_next;

  always_comb begin
    wr_next = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + 1'b1;
    rd_next = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;

    status.stored  = wr_req && (wr_next != rd_idx_r);
    status.dropped = wr_req && (wr_next == rd_idx_r);
    status.hit     = rd_req && (rd_idx_r != wr_idx_r);

    wr_idx_nxt = status.stored ? wr_next : wr_idx_r;
    rd_idx_nxt = status.hit ? rd_next : rd_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (status.stored) begin
      mem[wr_next] <= wr_byte;
    end
    if (status.hit) begin
      rdata_r <= mem[rd_next];
    end
  end

  assign rdata = rdata_r;

  a_store_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    status.stored |=> wr_idx_r != rd_idx_r)
    else $error("store left queue looking empty");

  a_empty_read_still: assert property (@(posedge clk) disable iff (!rst_n)
    rd_req && !status.hit |=> $stable(rd_idx_r) && rd_idx_r == wr_idx_r)
    else $error("empty read moved read index");

  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_req && rd_req))
    else $error("write and read in same cycle");

endmodule
